### design/flr_pkg.sv
// Shared constants, codes and request types of the feathered line rasterizer.
package flr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    localparam int ALPHA_W  = 8;
    localparam int DIM_W    = 9;
    localparam int RAD_W    = 8;
    localparam int CFG_W    = 9;
    localparam int CNT_W    = 17;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int NUM_W    = 58;
    localparam int DEN_W    = 38;
    localparam int QUO_W    = 24;
    localparam int SQ_IN_W  = 24;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    localparam logic [DIM_W-1:0]   RST_FRAME_W   = DIM_W'(256);
    localparam logic [DIM_W-1:0]   RST_FRAME_H   = DIM_W'(256);
    localparam logic [RAD_W-1:0]   RST_CORE      = RAD_W'(7);
    localparam logic [RAD_W-1:0]   RST_FEATHER   = RAD_W'(15);
    localparam logic [ALPHA_W-1:0] RST_MAX_ALPHA = ALPHA_W'(92);

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_FRAME_W   = 3'd0,
        CFG_FRAME_H   = 3'd1,
        CFG_CORE      = 3'd2,
        CFG_FEATHER   = 3'd3,
        CFG_MAX_ALPHA = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } t_div_rsp;

    typedef struct packed {
        logic                start;
        logic [SQ_IN_W-1:0]  val;
    } t_sqrt_req;

    typedef struct packed {
        logic                 done;
        logic [SQ_OUT_W-1:0]  root;
    } t_sqrt_rsp;

endpackage

### design/feathered_line_raster.sv
// Top level of the feathered line rasterizer: sequencer, setup math and alpha store.
//
// A draw runs the setup states S_SU0 to S_SU8, then visits each pixel of the widened,
// clamped bounding box. A pixel in the feather band beside the segment body passes twice
// through the iterative divider and once through the square-root unit; a feather band
// pixel past an endpoint needs one divider pass. One shared multiplier serves all
// products. A clear sweeps the store one pixel per cycle, and the same sweep runs
// after reset, during which busy stays high. The block takes one item at a time;
// o_done marks each result for one cycle, and the receiver cannot stall it, so every
// result must be taken in that cycle.
module feathered_line_raster (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    output logic                           o_done,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_idx,
    input  logic [flr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [1:0]                     i_opcode,
    input  logic signed [15:0]             i_x_start,
    input  logic signed [15:0]             i_y_start,
    input  logic signed [15:0]             i_x_end,
    input  logic signed [15:0]             i_y_end,
    input  logic [7:0]                     i_pixel_x,
    input  logic [7:0]                     i_pixel_y,
    output logic [flr_pkg::ALPHA_W-1:0]    o_pixel_alpha,
    output logic [flr_pkg::CNT_W-1:0]      o_pixels_raised,
    output logic                           o_segment_skipped
);

    typedef enum logic [5:0] {
        S_IDLE, S_CLEAR, S_RD, S_RD1,
        S_SU0, S_SU1, S_SU2, S_SU3, S_SU4, S_SU5, S_SU6, S_SU7, S_SU8,
        S_PX0, S_PX1, S_PX2, S_PX3, S_PX4,
        S_EP1, S_EP2, S_SG0, S_SG1, S_DIVQ, S_SQRT,
        S_AL0, S_AL1, S_AL2, S_AL3, S_AL4, S_AL5, S_DIVA, S_WR
    } t_state;

    localparam int AW = flr_pkg::ADDR_W;
    localparam int XW = flr_pkg::X_W;
    localparam int YW = flr_pkg::Y_W;
    localparam int DW = flr_pkg::DIM_W;
    localparam int MW = flr_pkg::MUL_W;

    function automatic logic [XW-1:0] f_clamp(input logic signed [17:0] v,
                                              input logic [DW-1:0] lim);
        logic [XW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({9'b0, lim})) begin
            res = lim[XW-1:0];
        end else begin
            res = v[XW-1:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [DW-1:0]               r_fw, r_fh;
    logic [flr_pkg::RAD_W-1:0]   r_rc, r_rf;
    logic [flr_pkg::ALPHA_W-1:0] r_ma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= flr_pkg::RST_FRAME_W;
            r_fh <= flr_pkg::RST_FRAME_H;
            r_rc <= flr_pkg::RST_CORE;
            r_rf <= flr_pkg::RST_FEATHER;
            r_ma <= flr_pkg::RST_MAX_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flr_pkg::CFG_FRAME_W:   r_fw <= i_cfg_data;
                flr_pkg::CFG_FRAME_H:   r_fh <= i_cfg_data;
                flr_pkg::CFG_CORE:      r_rc <= i_cfg_data[flr_pkg::RAD_W-1:0];
                flr_pkg::CFG_FEATHER:   r_rf <= i_cfg_data[flr_pkg::RAD_W-1:0];
                flr_pkg::CFG_MAX_ALPHA: r_ma <= i_cfg_data[flr_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    t_state r_state;

    logic signed [15:0] r_xs, r_ys, r_xe, r_ye;
    logic [XW-1:0]      r_rd_x, r_x, r_x1;
    logic [YW-1:0]      r_rd_y, r_y, r_y1;
    logic [XW-1:0]      r_x0_keep;
    logic [AW-1:0]      r_clr_addr;
    logic               r_clr_report;

    logic signed [35:0] r_acc, r_dot, r_cr;
    logic [33:0]        r_lensq;
    logic [15:0]        r_rf2, r_rc2;
    logic [48:0]        r_rf2len, r_rc2len;
    logic [36:0]        r_m3;
    logic [36:0]        r_c;
    logic [11:0]        r_n;
    logic [flr_pkg::ALPHA_W-1:0] r_a, r_old;
    logic [flr_pkg::CNT_W-1:0]   r_raised;

    logic                        r_done;
    logic [flr_pkg::ALPHA_W-1:0] r_out_alpha;
    logic [flr_pkg::CNT_W-1:0]   r_out_raised;
    logic                        r_out_skip;

    // Shared units.
    logic signed [MW-1:0]             mul_a, mul_b;
    logic signed [flr_pkg::PROD_W-1:0] mul_p;
    flr_pkg::t_div_req  div_req;
    flr_pkg::t_div_rsp  div_rsp;
    flr_pkg::t_sqrt_req sq_req;
    flr_pkg::t_sqrt_rsp sq_rsp;

    flr_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));
    flr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    flr_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_rsp(sq_rsp));

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [flr_pkg::ALPHA_W-1:0] ram_wdata, ram_rdata;

    flr_ram #(.WIDTH(flr_pkg::ALPHA_W), .DEPTH(flr_pkg::DEPTH)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // Datapath terms.
    logic [DW-1:0]      w_act, h_act;
    logic signed [16:0] dx, dy;
    logic signed [18:0] px, py, ex, ey;
    logic signed [15:0] xmin, xmax, ymin, ymax;
    logic signed [17:0] lo_x, lo_y, hi_x, hi_y;
    logic               degenerate;
    logic               endp_start;
    logic signed [35:0] sum36, diff36;
    logic [35:0]        ac;
    logic [63:0]        c2;
    logic [11:0]        m, base, n0, n_n;
    logic [13:0]        three_m_2n;
    logic               no_band;
    logic [44:0]        t_prod;
    logic               wr_ok;
    logic               last_px;

    assign w_act = (r_fw > DW'(flr_pkg::MAX_WIDTH)) ? DW'(flr_pkg::MAX_WIDTH) : r_fw;
    assign h_act = (r_fh > DW'(flr_pkg::MAX_HEIGHT)) ? DW'(flr_pkg::MAX_HEIGHT) : r_fh;

    assign dx = {r_xe[15], r_xe} - {r_xs[15], r_xs};
    assign dy = {r_ye[15], r_ye} - {r_ys[15], r_ys};
    assign px = $signed({7'b0, r_x, 4'b1000}) - $signed({{3{r_xs[15]}}, r_xs});
    assign py = $signed({7'b0, r_y, 4'b1000}) - $signed({{3{r_ys[15]}}, r_ys});

    assign endp_start = r_dot <= 0;
    assign ex = endp_start ? px : px - 19'(dx);
    assign ey = endp_start ? py : py - 19'(dy);

    assign xmin = (r_xs < r_xe) ? r_xs : r_xe;
    assign xmax = (r_xs > r_xe) ? r_xs : r_xe;
    assign ymin = (r_ys < r_ye) ? r_ys : r_ye;
    assign ymax = (r_ys > r_ye) ? r_ys : r_ye;
    assign lo_x = 18'(xmin) - $signed({10'b0, r_rf}) - 18'sd16;
    assign lo_y = 18'(ymin) - $signed({10'b0, r_rf}) - 18'sd16;
    assign hi_x = 18'(xmax) + $signed({10'b0, r_rf}) + 18'sd31;
    assign hi_y = 18'(ymax) + $signed({10'b0, r_rf}) + 18'sd31;

    assign degenerate = (dx == 0 && dy == 0) || w_act == 0 || h_act == 0;

    assign sum36  = r_acc + mul_p[35:0];
    assign diff36 = r_acc - mul_p[35:0];
    assign ac     = r_cr[35] ? 36'(-r_cr) : 36'(r_cr);
    assign c2     = mul_p[63:0];

    assign m          = {r_rf - r_rc, 4'b0};
    assign base       = {r_rc, 4'b0};
    assign n0         = (sq_rsp.root > base) ? sq_rsp.root - base : '0;
    assign n_n        = (n0 > m) ? m : n0;
    assign three_m_2n = ({2'b0, m} + {1'b0, m, 1'b0}) - {1'b0, r_n, 1'b0};
    assign no_band    = r_rf <= r_rc;
    assign t_prod     = {r_acc[26:0], 18'b0} + mul_p[44:0];

    assign wr_ok   = r_a != 0 && r_a > r_old;
    assign last_px = r_x == r_x1 && r_y == r_y1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SU0: begin mul_a = MW'(dx); mul_b = MW'(dx); end
            S_SU1: begin mul_a = MW'(dy); mul_b = MW'(dy); end
            S_SU2: begin mul_a = MW'(r_rf); mul_b = MW'(r_rf); end
            S_SU3: begin mul_a = MW'(r_rc); mul_b = MW'(r_rc); end
            S_SU4: begin mul_a = MW'(r_rf2); mul_b = MW'(r_lensq); end
            S_SU5: begin mul_a = MW'(r_rc2); mul_b = MW'(r_lensq); end
            S_SU6: begin mul_a = MW'(m); mul_b = MW'(m); end
            S_SU7: begin mul_a = MW'(mul_p[23:0]); mul_b = MW'(m); end
            S_PX0: begin mul_a = MW'(px); mul_b = MW'(dx); end
            S_PX1: begin mul_a = MW'(py); mul_b = MW'(dy); end
            S_PX2: begin mul_a = MW'(px); mul_b = MW'(dy); end
            S_PX3: begin mul_a = MW'(py); mul_b = MW'(dx); end
            S_PX4: begin mul_a = MW'(ex); mul_b = MW'(ex); end
            S_EP1: begin mul_a = MW'(ey); mul_b = MW'(ey); end
            S_SG0: begin mul_a = MW'(ac[31:0]); mul_b = MW'(ac[31:0]); end
            S_AL0: begin mul_a = MW'(r_n); mul_b = MW'(r_n); end
            S_AL1: begin mul_a = MW'(mul_p[23:0]); mul_b = MW'(three_m_2n); end
            S_AL3: begin mul_a = MW'(r_ma); mul_b = MW'(r_c[36:18]); end
            S_AL4: begin mul_a = MW'(r_ma); mul_b = MW'(r_c[17:0]); end
            default: ;
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = flr_pkg::NUM_W'({c2[48:0], 8'b0});
        div_req.den   = flr_pkg::DEN_W'(r_lensq);
        if (r_state == S_SG1) begin
            div_req.start = c2 <= 64'(r_rf2len) && c2 > 64'(r_rc2len) && !no_band;
        end else if (r_state == S_AL5) begin
            div_req.start = 1'b1;
            div_req.num   = flr_pkg::NUM_W'({t_prod, 1'b0}) + flr_pkg::NUM_W'(r_m3);
            div_req.den   = {r_m3, 1'b0};
        end
    end

    always_comb begin
        sq_req.start = 1'b0;
        sq_req.val   = div_rsp.quo;
        if (r_state == S_EP2) begin
            sq_req.start = sum36 <= 36'(r_rf2) && sum36 > 36'(r_rc2) && !no_band;
            sq_req.val   = {sum36[15:0], 8'b0};
        end else if (r_state == S_DIVQ) begin
            sq_req.start = div_rsp.done;
        end
    end

    assign ram_we    = r_state == S_CLEAR || (r_state == S_WR && wr_ok);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : {r_y, r_x};
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_a;
    assign ram_raddr = (r_state == S_RD) ? {r_rd_y, r_rd_x} : {r_y, r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_done       <= 1'b0;
            r_out_alpha  <= '0;
            r_out_raised <= '0;
            r_out_skip   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_xs   <= i_x_start;
                        r_ys   <= i_y_start;
                        r_xe   <= i_x_end;
                        r_ye   <= i_y_end;
                        r_rd_x <= i_pixel_x;
                        r_rd_y <= i_pixel_y;
                        unique case (i_opcode)
                            flr_pkg::OP_DRAW:  r_state <= S_SU0;
                            flr_pkg::OP_READ:  r_state <= S_RD;
                            flr_pkg::OP_CLEAR: begin
                                r_state      <= S_CLEAR;
                                r_clr_addr   <= '0;
                                r_clr_report <= 1'b1;
                            end
                            default: begin
                                r_done       <= 1'b1;
                                r_out_alpha  <= '0;
                                r_out_raised <= '0;
                                r_out_skip   <= 1'b0;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= S_IDLE;
                        if (r_clr_report) begin
                            r_done       <= 1'b1;
                            r_out_alpha  <= '0;
                            r_out_raised <= '0;
                            r_out_skip   <= 1'b0;
                        end
                    end
                end
                S_RD: r_state <= S_RD1;
                S_RD1: begin
                    r_state      <= S_IDLE;
                    r_done       <= 1'b1;
                    r_out_alpha  <= ({1'b0, r_rd_x} < w_act && {1'b0, r_rd_y} < h_act)
                                    ? ram_rdata : '0;
                    r_out_raised <= '0;
                    r_out_skip   <= 1'b0;
                end
                S_SU0: begin
                    r_x0_keep <= f_clamp(lo_x >>> 4, w_act - 1'b1);
                    r_x       <= f_clamp(lo_x >>> 4, w_act - 1'b1);
                    r_y       <= f_clamp(lo_y >>> 4, h_act - 1'b1);
                    r_x1      <= f_clamp(hi_x >>> 4, w_act - 1'b1);
                    r_y1      <= f_clamp(hi_y >>> 4, h_act - 1'b1);
                    r_raised  <= '0;
                    if (degenerate) begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_out_alpha  <= '0;
                        r_out_raised <= '0;
                        r_out_skip   <= 1'b1;
                    end else begin
                        r_state <= S_SU1;
                    end
                end
                S_SU1: begin r_acc <= mul_p[35:0]; r_state <= S_SU2; end
                S_SU2: begin r_lensq <= sum36[33:0]; r_state <= S_SU3; end
                S_SU3: begin r_rf2 <= mul_p[15:0]; r_state <= S_SU4; end
                S_SU4: begin r_rc2 <= mul_p[15:0]; r_state <= S_SU5; end
                S_SU5: begin r_rf2len <= mul_p[48:0]; r_state <= S_SU6; end
                S_SU6: begin r_rc2len <= mul_p[48:0]; r_state <= S_SU7; end
                S_SU7: r_state <= S_SU8;
                S_SU8: begin r_m3 <= mul_p[36:0]; r_state <= S_PX0; end
                S_PX0: r_state <= S_PX1;
                S_PX1: begin r_acc <= mul_p[35:0]; r_old <= ram_rdata; r_state <= S_PX2; end
                S_PX2: begin r_dot <= sum36; r_state <= S_PX3; end
                S_PX3: begin r_acc <= mul_p[35:0]; r_state <= S_PX4; end
                S_PX4: begin
                    r_cr <= diff36;
                    if (r_dot <= 0 || r_dot >= $signed({2'b0, r_lensq})) begin
                        r_state <= S_EP1;
                    end else begin
                        r_state <= S_SG0;
                    end
                end
                S_EP1: begin r_acc <= mul_p[35:0]; r_state <= S_EP2; end
                S_EP2: begin
                    if (sum36 > 36'(r_rf2)) begin
                        r_a     <= '0;
                        r_state <= S_WR;
                    end else if (sum36 <= 36'(r_rc2) || no_band) begin
                        r_a     <= r_ma;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SG0: begin
                    if (ac[35:32] != 0) begin
                        r_a     <= '0;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_SG1;
                    end
                end
                S_SG1: begin
                    if (c2 > 64'(r_rf2len)) begin
                        r_a     <= '0;
                        r_state <= S_WR;
                    end else if (c2 <= 64'(r_rc2len) || no_band) begin
                        r_a     <= r_ma;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ: if (div_rsp.done) r_state <= S_SQRT;
                S_SQRT: begin
                    if (sq_rsp.done) begin
                        r_n     <= n_n;
                        r_state <= S_AL0;
                    end
                end
                S_AL0: r_state <= S_AL1;
                S_AL1: r_state <= S_AL2;
                S_AL2: begin r_c <= r_m3 - mul_p[36:0]; r_state <= S_AL3; end
                S_AL3: r_state <= S_AL4;
                S_AL4: begin r_acc <= mul_p[35:0]; r_state <= S_AL5; end
                S_AL5: r_state <= S_DIVA;
                S_DIVA: begin
                    if (div_rsp.done) begin
                        r_a     <= div_rsp.quo[flr_pkg::ALPHA_W-1:0];
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_raised <= r_raised + flr_pkg::CNT_W'(wr_ok);
                    if (last_px) begin
                        r_state      <= S_IDLE;
                        r_done       <= 1'b1;
                        r_out_alpha  <= '0;
                        r_out_raised <= r_raised + flr_pkg::CNT_W'(wr_ok);
                        r_out_skip   <= 1'b0;
                    end else begin
                        r_state <= S_PX0;
                        if (r_x == r_x1) begin
                            r_x <= r_x0_keep;
                            r_y <= r_y + 1'b1;
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_done            = r_done;
    assign o_pixel_alpha     = r_out_alpha;
    assign o_pixels_raised   = r_out_raised;
    assign o_segment_skipped = r_out_skip;

endmodule

### design/flr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module flr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/flr_mul.sv
// Shared signed multiplier with a registered product.
module flr_mul (
    input  logic                              i_clk,
    input  logic signed [flr_pkg::MUL_W-1:0]  i_a,
    input  logic signed [flr_pkg::MUL_W-1:0]  i_b,
    output logic signed [flr_pkg::PROD_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

### design/flr_div.sv
// Iterative restoring divider producing one quotient bit per cycle.
module flr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  flr_pkg::t_div_req i_req,
    output flr_pkg::t_div_rsp o_rsp
);

    localparam int CW = $clog2(flr_pkg::QUO_W + 1);

    logic                        r_busy;
    logic [CW-1:0]               r_cnt;
    logic [flr_pkg::DEN_W-1:0]   r_rem;
    logic [flr_pkg::DEN_W-1:0]   r_den;
    logic [flr_pkg::QUO_W-1:0]   r_lo;
    logic [flr_pkg::QUO_W-1:0]   r_quo;
    logic                        r_done;
    logic [flr_pkg::DEN_W:0]     shifted;
    logic                        fits;

    assign shifted = {r_rem, r_lo[flr_pkg::QUO_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= flr_pkg::DEN_W'(i_req.num[flr_pkg::NUM_W-1:flr_pkg::QUO_W]);
                r_lo   <= i_req.num[flr_pkg::QUO_W-1:0];
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= fits ? flr_pkg::DEN_W'(shifted - {1'b0, r_den})
                              : shifted[flr_pkg::DEN_W-1:0];
                r_quo <= {r_quo[flr_pkg::QUO_W-2:0], fits};
                r_lo  <= {r_lo[flr_pkg::QUO_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(flr_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### design/flr_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module flr_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flr_pkg::t_sqrt_req i_req,
    output flr_pkg::t_sqrt_rsp o_rsp
);

    localparam int W  = flr_pkg::SQ_IN_W;
    localparam int CW = $clog2(flr_pkg::SQ_OUT_W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_v;
    logic [W-1:0]  r_res;
    logic [W-1:0]  r_bit;
    logic [W:0]    trial;
    logic          take;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign take  = {1'b0, r_v} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_req.val;
                r_res  <= '0;
                r_bit  <= W'(1) << (W - 2);
            end else if (r_busy) begin
                if (take) begin
                    r_v   <= W'({1'b0, r_v} - trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(flr_pkg::SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[flr_pkg::SQ_OUT_W-1:0];

endmodule

### design/flr_checker.sv
// Port-level checks of the feathered line rasterizer, bound to the top level.
module flr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_done,
    input logic [1:0]                  i_opcode,
    input logic [flr_pkg::ALPHA_W-1:0] o_pixel_alpha,
    input logic [flr_pkg::CNT_W-1:0]   o_pixels_raised,
    input logic                        o_segment_skipped
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("store clear pass did not start after reset");

    a_skip_no_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_segment_skipped |-> o_pixels_raised == 0 && o_pixel_alpha == 0)
        else $error("skipped draw reported work");

    a_alpha_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_pixel_alpha != 0 |-> o_pixels_raised == 0 && !o_segment_skipped)
        else $error("read result mixed with draw fields");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_opcode != flr_pkg::OP_NOP |=> o_busy)
        else $error("accepted item did not make the block busy");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy) || $past(i_start))
        else $error("result without a pending item");

endmodule

bind feathered_line_raster flr_checker u_flr_checker (.*);

### dv/feathered_line_raster_tb.sv
// Self-checking testbench of the feathered line rasterizer with its own alpha store model.
module feathered_line_raster_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 80_000_000;

    typedef struct {
        logic [flr_pkg::ALPHA_W-1:0] alpha;
        logic [flr_pkg::CNT_W-1:0]   raised;
        logic                        skipped;
    } t_raster_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start;
    logic                        o_busy;
    logic                        o_done;
    logic                        i_cfg_we;
    logic [2:0]                  i_cfg_idx;
    logic [flr_pkg::CFG_W-1:0]   i_cfg_data;
    logic [1:0]                  i_opcode;
    logic signed [15:0]          i_x_start;
    logic signed [15:0]          i_y_start;
    logic signed [15:0]          i_x_end;
    logic signed [15:0]          i_y_end;
    logic [7:0]                  i_pixel_x;
    logic [7:0]                  i_pixel_y;
    logic [flr_pkg::ALPHA_W-1:0] o_pixel_alpha;
    logic [flr_pkg::CNT_W-1:0]   o_pixels_raised;
    logic                        o_segment_skipped;

    feathered_line_raster i_dut (.*);

    t_raster_result   pending_results[$];
    logic [7:0]       alpha_mirror [0:flr_pkg::DEPTH-1];
    int unsigned      frame_w_reg;
    int unsigned      frame_h_reg;
    longint           core_reg;
    longint           feather_reg;
    longint           max_alpha_reg;
    int               idle_pct;
    int               error_count;
    longint           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int unsigned feather_alpha(longint unsigned q);
        longint unsigned dq;
        longint unsigned base;
        longint unsigned m;
        longint unsigned n;
        longint unsigned m3;
        longint unsigned c;
        dq = int_sqrt(q);
        base = 16 * core_reg;
        m = 16 * (feather_reg - core_reg);
        n = (dq > base) ? dq - base : 0;
        if (n > m) n = m;
        m3 = m * m * m;
        c = m3 - n * n * (3 * m - 2 * n);
        return int'((2 * max_alpha_reg * c + m3) / (2 * m3));
    endfunction

    function automatic longint active_w();
        return (frame_w_reg > flr_pkg::MAX_WIDTH) ? flr_pkg::MAX_WIDTH : frame_w_reg;
    endfunction

    function automatic longint active_h();
        return (frame_h_reg > flr_pkg::MAX_HEIGHT) ? flr_pkg::MAX_HEIGHT : frame_h_reg;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic rasterize_segment(input longint xs, input longint ys, input longint xe,
                                     input longint ye, output t_raster_result res);
        longint dx, dy, w, h, x0, x1, y0, y1, px, py, dot, ex, ey, cr;
        longint unsigned lensq, rf2len, rc2len, v, ac, c2, q;
        int unsigned a, raised;
        bit full;
        int idx;
        dx = xe - xs;
        dy = ye - ys;
        w = active_w();
        h = active_h();
        raised = 0;
        res.alpha = '0;
        res.raised = '0;
        res.skipped = 1'b0;
        if ((dx == 0 && dy == 0) || w == 0 || h == 0) begin
            res.skipped = 1'b1;
            return;
        end
        lensq = dx * dx + dy * dy;
        rf2len = feather_reg * feather_reg * lensq;
        rc2len = core_reg * core_reg * lensq;
        x0 = clampv(((xs < xe ? xs : xe) - feather_reg - 16) >>> 4, 0, w - 1);
        y0 = clampv(((ys < ye ? ys : ye) - feather_reg - 16) >>> 4, 0, h - 1);
        x1 = clampv(((xs > xe ? xs : xe) + feather_reg + 16 + 15) >>> 4, 0, w - 1);
        y1 = clampv(((ys > ye ? ys : ye) + feather_reg + 16 + 15) >>> 4, 0, h - 1);
        for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
                px = 16 * x + 8 - xs;
                py = 16 * y + 8 - ys;
                dot = px * dx + py * dy;
                if (dot <= 0 || dot >= longint'(lensq)) begin
                    ex = (dot <= 0) ? px : px - dx;
                    ey = (dot <= 0) ? py : py - dy;
                    v = ex * ex + ey * ey;
                    if (v > feather_reg * feather_reg) continue;
                    full = (v <= core_reg * core_reg);
                    q = 256 * v;
                end else begin
                    cr = px * dy - py * dx;
                    ac = (cr < 0) ? -cr : cr;
                    if (ac >= (64'd1 << 32)) continue;
                    c2 = ac * ac;
                    if (c2 > rf2len) continue;
                    full = (c2 <= rc2len);
                    q = (256 * c2) / lensq;
                end
                if (full || feather_reg <= core_reg) a = int'(max_alpha_reg);
                else a = feather_alpha(q);
                if (a == 0) continue;
                idx = int'(y) * flr_pkg::MAX_WIDTH + int'(x);
                if (a > alpha_mirror[idx]) begin
                    alpha_mirror[idx] = a[7:0];
                    raised++;
                end
            end
        end
        res.raised = raised[flr_pkg::CNT_W-1:0];
    endtask

    task automatic predict_item(input flr_pkg::t_op op, input logic signed [15:0] xs,
                                input logic signed [15:0] ys, input logic signed [15:0] xe,
                                input logic signed [15:0] ye, input logic [7:0] px,
                                input logic [7:0] py);
        t_raster_result res;
        res.alpha = '0;
        res.raised = '0;
        res.skipped = 1'b0;
        case (op)
            flr_pkg::OP_DRAW: begin
                rasterize_segment(xs, ys, xe, ye, res);
            end
            flr_pkg::OP_READ: begin
                if (px < active_w() && py < active_h())
                    res.alpha = alpha_mirror[int'(py) * flr_pkg::MAX_WIDTH + int'(px)];
            end
            flr_pkg::OP_CLEAR: begin
                foreach (alpha_mirror[i]) alpha_mirror[i] = '0;
            end
            default: begin
            end
        endcase
        pending_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_raster_result exp_res;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no pending transfer");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_pixel_alpha !== exp_res.alpha) begin
                    $error("pixel_alpha expected %0d actual %0d", exp_res.alpha, o_pixel_alpha);
                    error_count++;
                end
                if (o_pixels_raised !== exp_res.raised) begin
                    $error("pixels_raised expected %0d actual %0d",
                           exp_res.raised, o_pixels_raised);
                    error_count++;
                end
                if (o_segment_skipped !== exp_res.skipped) begin
                    $error("segment_skipped expected %0d actual %0d",
                           exp_res.skipped, o_segment_skipped);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input flr_pkg::t_op op, input logic signed [15:0] xs,
                             input logic signed [15:0] ys, input logic signed [15:0] xe,
                             input logic signed [15:0] ye, input logic [7:0] px,
                             input logic [7:0] py);
        i_opcode = op;
        i_x_start = xs;
        i_y_start = ys;
        i_x_end = xe;
        i_y_end = ye;
        i_pixel_x = px;
        i_pixel_y = py;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        predict_item(op, xs, ys, xe, ye, px, py);
        @(negedge i_clk);
        i_start = 1'b0;
        if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 8)) @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input flr_pkg::t_cfg_idx idx, input int unsigned value);
        drain_results();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[flr_pkg::CFG_W-1:0];
        case (idx)
            flr_pkg::CFG_FRAME_W:   frame_w_reg = value & 9'h1FF;
            flr_pkg::CFG_FRAME_H:   frame_h_reg = value & 9'h1FF;
            flr_pkg::CFG_CORE:      core_reg = value & 8'hFF;
            flr_pkg::CFG_FEATHER:   feather_reg = value & 8'hFF;
            flr_pkg::CFG_MAX_ALPHA: max_alpha_reg = value & 8'hFF;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_raster(input int unsigned w, input int unsigned h, input int unsigned rc,
                              input int unsigned rf, input int unsigned ma);
        write_reg(flr_pkg::CFG_FRAME_W, w);
        write_reg(flr_pkg::CFG_FRAME_H, h);
        write_reg(flr_pkg::CFG_CORE, rc);
        write_reg(flr_pkg::CFG_FEATHER, rf);
        write_reg(flr_pkg::CFG_MAX_ALPHA, ma);
    endtask

    task automatic test_basic_ops();
        idle_pct = 0;
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd0, 8'd0);
        send_item(flr_pkg::OP_DRAW, 16, 16, 160, 16, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd3, 8'd1);
        send_item(flr_pkg::OP_DRAW, 40, 200, 40, 24, 0, 0);
        send_item(flr_pkg::OP_DRAW, -40, -40, 40, 40, 0, 0);
        send_item(flr_pkg::OP_DRAW, 100, 100, 100, 100, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd255, 8'd255);
        send_item(flr_pkg::OP_NOP, -1, -1, -1, -1, 8'hFF, 8'hFF);
        send_item(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd3, 8'd1);
    endtask

    task automatic test_frame_edges();
        set_raster(16, 16, 7, 15, 92);
        send_item(flr_pkg::OP_DRAW, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd15, 8'd15);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd255, 8'd255);
        write_reg(flr_pkg::CFG_FRAME_W, 0);
        send_item(flr_pkg::OP_DRAW, 16, 16, 64, 64, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd1, 8'd1);
        write_reg(flr_pkg::CFG_FRAME_W, 1);
        write_reg(flr_pkg::CFG_FRAME_H, 1);
        send_item(flr_pkg::OP_DRAW, 0, 8, 32, 8, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd0, 8'd0);
        write_reg(flr_pkg::CFG_FRAME_W, 511);
        write_reg(flr_pkg::CFG_FRAME_H, 300);
        send_item(flr_pkg::OP_DRAW, 4070, 4070, 4095, 4090, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd255, 8'd255);
    endtask

    task automatic test_radius_extremes();
        set_raster(16, 16, 0, 255, 255);
        send_item(flr_pkg::OP_DRAW, 128, 128, 129, 128, 0, 0);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd8, 8'd8);
        set_raster(16, 16, 255, 255, 200);
        send_item(flr_pkg::OP_DRAW, 40, 40, 200, 90, 0, 0);
        set_raster(16, 16, 40, 10, 77);
        send_item(flr_pkg::OP_DRAW, 200, 40, 40, 200, 0, 0);
        write_reg(flr_pkg::CFG_MAX_ALPHA, 0);
        send_item(flr_pkg::OP_DRAW, 8, 8, 120, 120, 0, 0);
        write_reg(flr_pkg::t_cfg_idx'(3'd5), 9'h1AB);
        write_reg(flr_pkg::t_cfg_idx'(3'd7), 9'h000);
        send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'd4, 8'd4);
        send_item(flr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int items, input int unsigned w,
                                       input int unsigned h, input int unsigned rc,
                                       input int unsigned rf, input int unsigned ma,
                                       input int idle, input bit noisy, input bit hold_off);
        int sel, span_x, span_y;
        logic signed [15:0] xs, ys, xe, ye;
        set_raster(w, h, rc, rf, ma);
        idle_pct = idle;
        span_x = (active_w() > 40) ? 40 : int'(active_w());
        span_y = (active_h() > 40) ? 40 : int'(active_h());
        for (int n = 0; n < items; n++) begin
            if (hold_off && n == items / 2) drain_results();
            sel = $urandom_range(0, 199);
            if (sel < 120) begin
                if (noisy && $urandom_range(0, 9) == 0) begin
                    xs = 16'($urandom);
                    ys = 16'($urandom);
                    xe = 16'($urandom);
                    ye = 16'($urandom);
                end else begin
                    xs = 16'($urandom_range(0, span_x * 16 + 32) - 16);
                    ys = 16'($urandom_range(0, span_y * 16 + 32) - 16);
                    xe = 16'(xs + $urandom_range(0, 96) - 48);
                    ye = 16'(ys + $urandom_range(0, 96) - 48);
                    if ($urandom_range(0, 19) == 0) begin
                        xe = xs;
                        ye = ys;
                    end
                end
                send_item(flr_pkg::OP_DRAW, xs, ys, xe, ye, 8'($urandom), 8'($urandom));
            end else if (sel < 190) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(flr_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_item(flr_pkg::OP_READ, 0, 0, 0, 0, 8'($urandom_range(0, span_x + 1)),
                              8'($urandom_range(0, span_y + 1)));
            end else if (sel < 199) begin
                send_item(flr_pkg::OP_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                send_item(flr_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_opcode = '0;
        i_x_start = '0;
        i_y_start = '0;
        i_x_end = '0;
        i_y_end = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        error_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        frame_w_reg = 256;
        frame_h_reg = 256;
        core_reg = 7;
        feather_reg = 15;
        max_alpha_reg = 92;
        foreach (alpha_mirror[i]) alpha_mirror[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        drain_results();

        test_basic_ops();
        test_frame_edges();
        test_radius_extremes();
        test_random_traffic(450, 256, 256, 7, 15, 92, 0, 1'b0, 1'b0);
        test_random_traffic(450, 12, 10, 0, 40, 255, 80, 1'b1, 1'b1);
        test_random_traffic(450, 300, 20, 16, 16, 200, 0, 1'b1, 1'b0);
        test_random_traffic(450, 48, 30, 8, 40, 128, 22, 1'b0, 1'b1);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

### sim.f
design/flr_pkg.sv
design/flr_ram.sv
design/flr_mul.sv
design/flr_div.sv
design/flr_sqrt.sv
design/feathered_line_raster.sv
design/flr_checker.sv
dv/feathered_line_raster_tb.sv
